// ----- rtl/q2e_pkg.sv -----
// Shared widths, constants and the arctangent table for the quaternion to Euler angle unit.
package q2e_pkg;

    localparam int SW = 35;
    localparam int RW = 33;
    localparam int QW = 31;
    localparam int FRAC = 28;
    localparam int CW = 38;
    localparam int ZW = 25;
    localparam int ATAN_LEN = 24;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic signed [ZW-1:0] PI_Q20 = 25'sd3294199;
    localparam logic signed [ZW-1:0] HALF_PI_Q20 = 25'sd1647099;
    localparam int PI_Q13 = 25736;
    localparam int HALF_PI_Q13 = 12868;
    localparam logic signed [SW-1:0] ONE_Q28 = 35'sd268435456;

    typedef logic signed [SW-1:0] t_sum;

    function automatic logic signed [ZW-1:0] atan_q20(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            5'd0: v = 25'sd823550;
            5'd1: v = 25'sd486170;
            5'd2: v = 25'sd256879;
            5'd3: v = 25'sd130396;
            5'd4: v = 25'sd65451;
            5'd5: v = 25'sd32757;
            5'd6: v = 25'sd16383;
            5'd7: v = 25'sd8192;
            5'd8: v = 25'sd4096;
            5'd9: v = 25'sd2048;
            5'd10: v = 25'sd1024;
            5'd11: v = 25'sd512;
            5'd12: v = 25'sd256;
            5'd13: v = 25'sd128;
            5'd14: v = 25'sd64;
            5'd15: v = 25'sd32;
            5'd16: v = 25'sd16;
            5'd17: v = 25'sd8;
            5'd18: v = 25'sd4;
            5'd19: v = 25'sd2;
            5'd20: v = 25'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/quaternion_to_euler_angles_unit.sv -----
// Top level of the quaternion to Z-Y-X Euler angle converter.
//
// An item is a unit quaternion (w, x, y, z, signed Q1.14) and is accepted at a
// rising edge with start high and busy low. Busy is never raised, so one item
// may be accepted in every cycle.
// Each item gives one beat with roll, yaw (signed Q2.13, saturated to plus or
// minus pi) and pitch (saturated to plus or minus pi/2), marked by o_valid for
// one cycle. The receiver cannot stall; beats leave in order of acceptance.
// An item passes, from the accepting edge to the edge that takes the beat,
// three stages for input, products and sums, then 31 square root
// stages (one root bit each), one CORDIC set-up stage, one stage per CORDIC
// iteration and one rounding and saturation stage. Throughput is one item per
// cycle. CORDIC_STEPS above 24 acts as 24.
// Reset clears the valid bits of every stage, so items in flight are dropped.
module quaternion_to_euler_angles_unit
    import q2e_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_quat_w,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    output logic               o_valid,
    output logic signed [15:0] o_roll_angle,
    output logic signed [14:0] o_pitch_angle,
    output logic signed [15:0] o_yaw_angle
);

    localparam int NS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
    localparam int LAT = 3 + QW + 2 + NS;

    logic               r_va, r_vb, r_vc;
    logic signed [15:0] r_w, r_x, r_y, r_z;
    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_xz;
    t_sum               r_sr, r_cr, r_sy, r_cy;
    logic [RW-1:0]      r_ra, r_rb;
    t_sum               n_t, n_a, n_b;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            r_va <= start && !busy;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_comb begin
        n_t = (SW'(r_wy) - SW'(r_xz)) <<< 1;
        n_a = ONE_Q28 + n_t;
        n_b = ONE_Q28 - n_t;
    end

    always_ff @(posedge i_clk) begin
        r_w <= i_quat_w;
        r_x <= i_quat_x;
        r_y <= i_quat_y;
        r_z <= i_quat_z;
        r_wx <= r_w * r_x;
        r_yz <= r_y * r_z;
        r_xx <= r_x * r_x;
        r_yy <= r_y * r_y;
        r_wz <= r_w * r_z;
        r_xy <= r_x * r_y;
        r_zz <= r_z * r_z;
        r_wy <= r_w * r_y;
        r_xz <= r_x * r_z;
        r_sr <= (SW'(r_wx) + SW'(r_yz)) <<< 1;
        r_cr <= ONE_Q28 - ((SW'(r_xx) + SW'(r_yy)) <<< 1);
        r_sy <= (SW'(r_wz) + SW'(r_xy)) <<< 1;
        r_cy <= ONE_Q28 - ((SW'(r_yy) + SW'(r_zz)) <<< 1);
        r_ra <= (n_a < 0) ? '0 : n_a[RW-1:0];
        r_rb <= (n_b < 0) ? '0 : n_b[RW-1:0];
    end

    logic              q_valid;
    logic [QW-1:0]     q_sp, q_cp;
    logic [4*SW-1:0]   q_side;
    t_sum              d_sr, d_cr, d_sy, d_cy;

    q2e_isqrt #(
        .PW(4 * SW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vc),
        .i_rad_a (r_ra),
        .i_rad_b (r_rb),
        .i_side  ({r_sr, r_cr, r_sy, r_cy}),
        .o_valid (q_valid),
        .o_root_a(q_sp),
        .o_root_b(q_cp),
        .o_side  (q_side)
    );

    assign {d_sr, d_cr, d_sy, d_cy} = q_side;

    logic                 c_valid;
    logic signed [ZW-1:0] c_roll, c_pitch, c_yaw;

    q2e_cordic #(
        .NS(NS)
    ) u_cordic_roll (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .i_x    (CW'(d_cr)),
        .i_y    (CW'(d_sr)),
        .o_valid(c_valid),
        .o_z    (c_roll)
    );

    q2e_cordic #(
        .NS(NS)
    ) u_cordic_pitch (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .i_x    ($signed({{(CW-QW){1'b0}}, q_cp})),
        .i_y    ($signed({{(CW-QW){1'b0}}, q_sp})),
        .o_valid(),
        .o_z    (c_pitch)
    );

    q2e_cordic #(
        .NS(NS)
    ) u_cordic_yaw (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .i_x    (CW'(d_cy)),
        .i_y    (CW'(d_sy)),
        .o_valid(),
        .o_z    (c_yaw)
    );

    logic signed [ZW:0]   roll_q, yaw_q;
    logic signed [ZW+1:0] pitch_z, pitch_q;
    logic signed [15:0]   n_roll, n_yaw;
    logic signed [14:0]   n_pitch;

    always_comb begin
        roll_q = ((ZW+1)'(c_roll) + (ZW+1)'(64)) >>> 7;
        yaw_q = ((ZW+1)'(c_yaw) + (ZW+1)'(64)) >>> 7;
        pitch_z = ((ZW+2)'(c_pitch) <<< 1) - (ZW+2)'(HALF_PI_Q20);
        pitch_q = (pitch_z + (ZW+2)'(64)) >>> 7;

        if (roll_q > PI_Q13) begin
            n_roll = 16'(PI_Q13);
        end else if (roll_q < -PI_Q13) begin
            n_roll = 16'(-PI_Q13);
        end else begin
            n_roll = roll_q[15:0];
        end

        if (yaw_q > PI_Q13) begin
            n_yaw = 16'(PI_Q13);
        end else if (yaw_q < -PI_Q13) begin
            n_yaw = 16'(-PI_Q13);
        end else begin
            n_yaw = yaw_q[15:0];
        end

        if (pitch_q > HALF_PI_Q13) begin
            n_pitch = 15'(HALF_PI_Q13);
        end else if (pitch_q < -HALF_PI_Q13) begin
            n_pitch = 15'(-HALF_PI_Q13);
        end else begin
            n_pitch = pitch_q[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_roll_angle <= n_roll;
        o_pitch_angle <= n_pitch;
        o_yaw_angle <= n_yaw;
    end

`ifndef SYNTHESIS
    a_beat_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result beat without an accepted item");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_roll_angle <= PI_Q13) && (o_roll_angle >= -PI_Q13)
            && (o_yaw_angle <= PI_Q13) && (o_yaw_angle >= -PI_Q13))
        else $error("roll or yaw out of range");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_angle <= HALF_PI_Q13) && (o_pitch_angle >= -HALF_PI_Q13))
        else $error("pitch out of range");
`endif

endmodule

// ----- rtl/q2e_isqrt.sv -----
// Pipelined integer square root of two radicands, one root bit per stage, with side data.
module q2e_isqrt
    import q2e_pkg::*;
#(
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [RW-1:0] i_rad_a,
    input  logic [RW-1:0] i_rad_b,
    input  logic [PW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_root_a,
    output logic [QW-1:0] o_root_b,
    output logic [PW-1:0] o_side
);

    localparam int DW = 2 * QW;
    localparam int MW = QW + 4;

    logic          r_vld  [0:QW-1];
    logic [PW-1:0] r_side [0:QW-1];
    logic [DW-1:0] r_rad_a [0:QW-1];
    logic [DW-1:0] r_rad_b [0:QW-1];
    logic [MW-1:0] r_rem_a [0:QW-1];
    logic [MW-1:0] r_rem_b [0:QW-1];
    logic [QW-1:0] r_root_a [0:QW-1];
    logic [QW-1:0] r_root_b [0:QW-1];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic          p_vld;
        logic [PW-1:0] p_side;
        logic [DW-1:0] p_rad_a, p_rad_b;
        logic [MW-1:0] p_rem_a, p_rem_b;
        logic [QW-1:0] p_root_a, p_root_b;
        logic [MW-1:0] pre_a, pre_b, trial_a, trial_b;

        if (s == 0) begin : g_first
            assign p_vld = i_valid;
            assign p_side = i_side;
            assign p_rad_a = {{(DW-RW-FRAC){1'b0}}, i_rad_a, {FRAC{1'b0}}};
            assign p_rad_b = {{(DW-RW-FRAC){1'b0}}, i_rad_b, {FRAC{1'b0}}};
            assign p_rem_a = '0;
            assign p_rem_b = '0;
            assign p_root_a = '0;
            assign p_root_b = '0;
        end else begin : g_next
            assign p_vld = r_vld[s-1];
            assign p_side = r_side[s-1];
            assign p_rad_a = r_rad_a[s-1];
            assign p_rad_b = r_rad_b[s-1];
            assign p_rem_a = r_rem_a[s-1];
            assign p_rem_b = r_rem_b[s-1];
            assign p_root_a = r_root_a[s-1];
            assign p_root_b = r_root_b[s-1];
        end

        assign pre_a = {p_rem_a[MW-3:0], p_rad_a[DW-1:DW-2]};
        assign pre_b = {p_rem_b[MW-3:0], p_rad_b[DW-1:DW-2]};
        assign trial_a = {2'b00, p_root_a, 2'b01};
        assign trial_b = {2'b00, p_root_b, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[s] <= p_side;
            r_rad_a[s] <= {p_rad_a[DW-3:0], 2'b00};
            r_rad_b[s] <= {p_rad_b[DW-3:0], 2'b00};
            if (pre_a >= trial_a) begin
                r_rem_a[s] <= pre_a - trial_a;
                r_root_a[s] <= {p_root_a[QW-2:0], 1'b1};
            end else begin
                r_rem_a[s] <= pre_a;
                r_root_a[s] <= {p_root_a[QW-2:0], 1'b0};
            end
            if (pre_b >= trial_b) begin
                r_rem_b[s] <= pre_b - trial_b;
                r_root_b[s] <= {p_root_b[QW-2:0], 1'b1};
            end else begin
                r_rem_b[s] <= pre_b;
                r_root_b[s] <= {p_root_b[QW-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_root_a = r_root_a[QW-1];
    assign o_root_b = r_root_b[QW-1];
    assign o_side = r_side[QW-1];

endmodule

// ----- rtl/q2e_cordic.sv -----
// Pipelined vectoring CORDIC giving a four-quadrant arctangent in Q.20 radians.
module q2e_cordic
    import q2e_pkg::*;
#(
    parameter int NS = CORDIC_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    output logic                 o_valid,
    output logic signed [ZW-1:0] o_z
);

    logic                 r_vld  [0:NS];
    logic                 r_zero [0:NS];
    logic signed [CW-1:0] r_x    [0:NS];
    logic signed [CW-1:0] r_y    [0:NS];
    logic signed [ZW-1:0] r_z    [0:NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero[0] <= (i_x == '0) && (i_y == '0);
        if (i_x < 0) begin
            r_x[0] <= -i_x;
            r_y[0] <= -i_y;
            r_z[0] <= (i_y >= 0) ? PI_Q20 : -PI_Q20;
        end else begin
            r_x[0] <= i_x;
            r_y[0] <= i_y;
            r_z[0] <= '0;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_iter
        logic signed [CW-1:0] dx, dy;

        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else begin
                r_vld[i+1] <= r_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            r_zero[i+1] <= r_zero[i];
            if (r_y[i] > 0) begin
                r_x[i+1] <= r_x[i] + dx;
                r_y[i+1] <= r_y[i] - dy;
                r_z[i+1] <= r_z[i] + atan_q20(5'(i));
            end else begin
                r_x[i+1] <= r_x[i] - dx;
                r_y[i+1] <= r_y[i] + dy;
                r_z[i+1] <= r_z[i] - atan_q20(5'(i));
            end
        end
    end

    assign o_valid = r_vld[NS];
    assign o_z = r_zero[NS] ? '0 : r_z[NS];

endmodule
